/* rtl/core/heap_sort_subrange_top_assert.svh */
// ----------------------------------------------------------------------------
// heap_sort_subrange_top_assert.svh
// assertion macros shared by the heap sort block
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_SUBRANGE_TOP_ASSERT_SVH
`define HEAP_SORT_SUBRANGE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define HSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define HSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define HSS_ASSERT(lbl, prop, msg)
`define HSS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/core/hss_pkg.sv */
// ----------------------------------------------------------------------------
// hss_pkg
// shared types and register codes of the heap sort block
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RangeW = 6;

  // register index, taken from paddr bit 2
  localparam logic REG_RANGE_START = 1'b0;
  localparam logic REG_RANGE_END   = 1'b1;

  typedef logic signed [DataW-1:0] elem_t;

  // memory port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

/* rtl/core/hss_mem.sv */
// ----------------------------------------------------------------------------
// hss_mem
// element store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module hss_mem #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  hss_pkg::mem_ctl_t ctl_i,
  input  logic [AddrW-1:0] waddr_i,
  input  hss_pkg::elem_t   wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output hss_pkg::elem_t   rdata_o
);
  import hss_pkg::*;

  elem_t mem_q [Depth];
  elem_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/hss_sort.sv */
// ----------------------------------------------------------------------------
// hss_sort
// in-place heapsort sequencer over a window of the element store
// ----------------------------------------------------------------------------
module hss_sort #(
  parameter int unsigned MaxElems = 64,
  localparam int unsigned AddrW = (MaxElems > 1) ? $clog2(MaxElems) : 1,
  localparam int unsigned CntW = $clog2(MaxElems + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AddrW-1:0]  lo_i,
  input  logic [CntW-1:0]   size_i,
  output logic              done_o,
  output hss_pkg::mem_ctl_t mem_ctl_o,
  output logic [AddrW-1:0]  waddr_o,
  output hss_pkg::elem_t    wdata_o,
  output logic [AddrW-1:0]  raddr_o,
  input  hss_pkg::elem_t    rdata_i
);
  import hss_pkg::*;

  localparam int unsigned IdxW = CntW + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_SFT_L,
    ST_SFT_R,
    ST_SFT_CMP,
    ST_EXT_A,
    ST_EXT_B,
    ST_EXT_C
  } state_e;

  state_e           state_q, state_d;
  logic             extract_q, extract_d;
  logic [CntW-1:0]  bld_q, bld_d;
  logic [CntW-1:0]  ext_q, ext_d;
  logic [AddrW-1:0] node_q, node_d;
  logic [AddrW-1:0] lo_q, lo_d;
  logic             has_r_q, has_r_d;
  logic             done_q, done_d;
  elem_t            val_q, val_d;
  elem_t            lval_q, lval_d;
  elem_t            root_q, root_d;

  logic [IdxW-1:0]  child;
  logic [IdxW-1:0]  child_r;
  logic [IdxW-1:0]  ext_w;
  logic             pick_l, pick_r, sift_end;
  elem_t            big;

  assign child   = (IdxW'(node_q) << 1) + IdxW'(1);
  assign child_r = child + IdxW'(1);
  assign ext_w   = IdxW'(ext_q);

  // largest of hole value, left child and right child; ties keep the hole value, and the left child over the right
  always_comb begin
    pick_l = lval_q > val_q;
    big    = pick_l ? lval_q : val_q;
    pick_r = has_r_q && (rdata_i > big);
    if (pick_r) begin
      big = rdata_i;
    end
  end

  // memory port and next state
  always_comb begin
    mem_ctl_o = '0;
    waddr_o   = lo_q + node_q;
    wdata_o   = val_q;
    raddr_o   = lo_q;
    state_d   = state_q;
    extract_d = extract_q;
    bld_d     = bld_q;
    ext_d     = ext_q;
    node_d    = node_q;
    lo_d      = lo_q;
    has_r_d   = has_r_q;
    done_d    = 1'b0;
    val_d     = val_q;
    lval_d    = lval_q;
    root_d    = root_q;
    sift_end  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          lo_d      = lo_i;
          ext_d     = size_i;
          bld_d     = size_i >> 1;
          extract_d = 1'b0;
          state_d   = ST_BLD_RD;
        end
      end
      ST_BLD_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        raddr_o         = lo_q + AddrW'(bld_q - CntW'(1));
        state_d         = ST_BLD_LD;
      end
      ST_BLD_LD: begin
        val_d   = rdata_i;
        node_d  = AddrW'(bld_q - CntW'(1));
        state_d = ST_SFT_L;
      end
      ST_SFT_L: begin
        if (child < ext_w) begin
          mem_ctl_o.rd_en = 1'b1;
          raddr_o         = lo_q + child[AddrW-1:0];
          state_d         = ST_SFT_R;
        end else begin
          // leaf reached: drop the hole value here
          mem_ctl_o.wr_en = 1'b1;
          sift_end        = 1'b1;
        end
      end
      ST_SFT_R: begin
        lval_d  = rdata_i;
        has_r_d = child_r < ext_w;
        if (child_r < ext_w) begin
          mem_ctl_o.rd_en = 1'b1;
          raddr_o         = lo_q + child_r[AddrW-1:0];
        end
        state_d = ST_SFT_CMP;
      end
      ST_SFT_CMP: begin
        mem_ctl_o.wr_en = 1'b1;
        if (pick_l || pick_r) begin
          // child moves up into the hole
          wdata_o = big;
          node_d  = pick_r ? child_r[AddrW-1:0] : child[AddrW-1:0];
          state_d = ST_SFT_L;
        end else begin
          sift_end = 1'b1;
        end
      end
      ST_EXT_A: begin
        if (ext_q > CntW'(1)) begin
          ext_d           = ext_q - CntW'(1);
          mem_ctl_o.rd_en = 1'b1;
          raddr_o         = lo_q;
          state_d         = ST_EXT_B;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_EXT_B: begin
        root_d          = rdata_i;
        mem_ctl_o.rd_en = 1'b1;
        raddr_o         = lo_q + AddrW'(ext_q);
        state_d         = ST_EXT_C;
      end
      ST_EXT_C: begin
        // max goes to the tail, tail value sifts down from the root
        mem_ctl_o.wr_en = 1'b1;
        waddr_o         = lo_q + AddrW'(ext_q);
        wdata_o         = root_q;
        val_d           = rdata_i;
        node_d          = '0;
        state_d         = ST_SFT_L;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (sift_end) begin
      if (!extract_q && (bld_q != CntW'(1))) begin
        bld_d   = bld_q - CntW'(1);
        state_d = ST_BLD_RD;
      end else begin
        extract_d = 1'b1;
        state_d   = ST_EXT_A;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      extract_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      extract_q <= extract_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bld_q   <= bld_d;
    ext_q   <= ext_d;
    node_q  <= node_d;
    lo_q    <= lo_d;
    has_r_q <= has_r_d;
    val_q   <= val_d;
    lval_q  <= lval_d;
    root_q  <= root_d;
  end

  assign done_o = done_q;

endmodule

/* rtl/core/heap_sort_subrange_top.sv */
// ----------------------------------------------------------------------------
// heap_sort_subrange_top
// loads a list of signed words, heap-sorts a configured window of positions
// in place and streams the whole list back out, or on a bad range sends a
// single error beat in place of the list
//
//  channel   direction  handshake               payload
//  input     in         in_valid_i/in_ready_o   element_value_i, last_element_i
//  output    out        out_valid_o/out_ready_i sorted_value_o, last_output_o,
//                                               bounds_error_o
//  config    in/out     psel/penable/pwrite     paddr, pwdata, prdata
//
//  loading takes one beat per cycle; beats past MAX_ELEMENTS are dropped
//  the sort runs on a single-port-read store: each sift level steps through a
//  left read, a right read, and a compare and move
//  output beats leave one at a time; each next position is read from the store
//  as the previous beat leaves, and then waits in the output register
//  no input beat is taken from the last input beat until the last output beat
//  reset clears the load counter and sets the range to the full store; the store
//  itself needs no clearing since only written positions are read
// ----------------------------------------------------------------------------
`include "heap_sort_subrange_top_assert.svh"

module heap_sort_subrange_top #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hss_pkg::elem_t        element_value_i,
  input  logic                  last_element_i,
  // result stream
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hss_pkg::elem_t        sorted_value_o,
  output logic                  last_output_o,
  output logic                  bounds_error_o,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import hss_pkg::*;

  localparam int unsigned AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {
    ST_LOAD,   // taking input beats
    ST_CHECK,  // range check, kick off the sort
    ST_SORT,   // sequencer owns the store
    ST_RD,     // first read of the drain
    ST_SHOW,   // read data lands in the output register
    ST_HOLD    // output beat waits for the sink
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [RangeW-1:0]  range_start_q, range_end_q;
  logic               out_valid_q, out_valid_d;
  logic               last_output_q, last_output_d;
  logic               bounds_error_q, bounds_error_d;
  elem_t              sorted_value_q, sorted_value_d;

  // store ports as seen by the top
  mem_ctl_t           top_ctl, mem_ctl;
  logic [AddrW-1:0]   top_waddr, top_raddr, mem_waddr, mem_raddr;
  elem_t              mem_wdata, mem_rdata;

  // sequencer
  mem_ctl_t           sort_ctl;
  logic [AddrW-1:0]   sort_waddr, sort_raddr;
  elem_t              sort_wdata;
  logic               sort_start, sort_done;
  logic [CntW-1:0]    sort_size;

  logic               range_bad;
  logic               in_beat, out_beat, cfg_wr;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_beat   = out_valid_q && out_ready_i;

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= '0;
      range_end_q   <= '1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RANGE_START: range_start_q <= pwdata[RangeW-1:0];
        REG_RANGE_END:   range_end_q   <= pwdata[RangeW-1:0];
        default:         range_end_q   <= range_end_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RANGE_START: prdata = 32'(range_start_q);
      REG_RANGE_END:   prdata = 32'(range_end_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // range check and sort launch
  // ---------------------------------------------------------------------------
  // end must fall below the loaded count and not before start
  assign range_bad  = (range_start_q > range_end_q) || (32'(range_end_q) >= 32'(cnt_q));
  assign sort_size  = CntW'({1'b0, range_end_q} - {1'b0, range_start_q} + 7'd1);
  // a one-position window needs no sort
  assign sort_start = (state_q == ST_CHECK) && !range_bad && (range_end_q > range_start_q);

  hss_sort #(
    .MaxElems (MAX_ELEMENTS)
  ) u_sort (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sort_start),
    .lo_i      (range_start_q[AddrW-1:0]),
    .size_i    (sort_size),
    .done_o    (sort_done),
    .mem_ctl_o (sort_ctl),
    .waddr_o   (sort_waddr),
    .wdata_o   (sort_wdata),
    .raddr_o   (sort_raddr),
    .rdata_i   (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // control: load, check, sort, drain
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    pos_d          = pos_q;
    out_valid_d    = out_valid_q;
    last_output_d  = last_output_q;
    bounds_error_d = bounds_error_q;
    sorted_value_d = sorted_value_q;
    top_ctl        = '0;
    top_waddr      = cnt_q[AddrW-1:0];
    top_raddr      = pos_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          // a full store drops the beat but still honors its last flag
          if (cnt_q < CntW'(MAX_ELEMENTS)) begin
            top_ctl.wr_en = 1'b1;
            cnt_d         = cnt_q + CntW'(1);
          end
          if (last_element_i) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        pos_d = '0;
        if (range_bad) begin
          // single error beat, list discarded
          out_valid_d    = 1'b1;
          sorted_value_d = '0;
          last_output_d  = 1'b1;
          bounds_error_d = 1'b1;
          state_d        = ST_HOLD;
        end else if (sort_start) begin
          state_d = ST_SORT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_SORT: begin
        if (sort_done) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        top_ctl.rd_en = 1'b1;
        state_d       = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid_d    = 1'b1;
        sorted_value_d = mem_rdata;
        last_output_d  = (CntW'(pos_q) + CntW'(1)) == cnt_q;
        bounds_error_d = 1'b0;
        state_d        = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_beat) begin
          out_valid_d = 1'b0;
          if (last_output_q) begin
            cnt_d   = '0;
            state_d = ST_LOAD;
          end else begin
            // fetch the next position in the same cycle the beat leaves
            pos_d         = pos_q + AddrW'(1);
            top_raddr     = pos_q + AddrW'(1);
            top_ctl.rd_en = 1'b1;
            state_d       = ST_SHOW;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q          <= pos_d;
    last_output_q  <= last_output_d;
    bounds_error_q <= bounds_error_d;
    sorted_value_q <= sorted_value_d;
  end

  // ---------------------------------------------------------------------------
  // element store, owned by the sequencer while it runs
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state_q == ST_SORT) begin
      mem_ctl   = sort_ctl;
      mem_waddr = sort_waddr;
      mem_wdata = sort_wdata;
      mem_raddr = sort_raddr;
    end else begin
      mem_ctl   = top_ctl;
      mem_waddr = top_waddr;
      mem_wdata = element_value_i;
      mem_raddr = top_raddr;
    end
  end

  hss_mem #(
    .Depth (MAX_ELEMENTS)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = sorted_value_q;
  assign last_output_o  = last_output_q;
  assign bounds_error_o = bounds_error_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // input and output sides are never open together; state is unknown before
  // the first edge under reset
  `HSS_ASSERT_ALWAYS(a_no_overlap, !rst_ni || !(in_ready_o && out_valid_o), "load and drain overlap")

  // the last output beat reopens the input side
  `HSS_ASSERT(a_reopen, (out_valid_o && out_ready_i && last_output_o) |=> in_ready_o,
              "input not reopened after run")

  // an error beat is always a lone zero beat
  `HSS_ASSERT(a_err_beat,
              (out_valid_o && bounds_error_o) |-> (last_output_o && (sorted_value_o == 0)),
              "malformed error beat")

  // load count stays within the store
  `HSS_ASSERT(a_cnt_range, 32'(cnt_q) <= MAX_ELEMENTS, "load count overflow")

endmodule
